@@ sv/tks_pkg.sv @@
// Package: shared constants, types and the entry order function.
package tks_pkg;
	localparam int unsigned QueueDepthDef = 16;
	localparam int unsigned ValueBitsDef = 32;
	localparam int unsigned CapResetVal = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_DUMP,
		ST_STATUS
	} state_t;

	typedef struct packed {
		logic load_push;
		logic do_insert;
		logic dump_start;
		logic dump_adv;
	} cmd_t;

	typedef struct packed {
		logic dump_last;
		logic empty;
	} stat_t;

	function automatic logic [31:0] order_of(input logic [31:0] b);
		logic [31:0] x;
		x = (b == 32'h8000_0000) ? 32'h0 : b;
		return x[31] ? ~x : (x | 32'h8000_0000);
	endfunction
endpackage

@@ sv/tks_if.sv @@
// Interfaces: request and result channels.
interface tks_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] score;
	logic [31:0] coord_u;
	logic [31:0] coord_v;
	logic [31:0] lattice_modulus;
	modport source (output valid, req_type, score, coord_u, coord_v, lattice_modulus,
		input ready);
	modport sink (input valid, req_type, score, coord_u, coord_v, lattice_modulus,
		output ready);
endinterface

interface tks_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_u;
	logic [31:0] out_v;
	logic [31:0] out_modulus;
	logic [31:0] out_score;
	logic        entry_valid;
	logic        last_entry;
	logic [4:0]  stored_count;
	modport source (output valid, out_u, out_v, out_modulus, out_score, entry_valid,
		last_entry, stored_count, input ready);
	modport sink (input valid, out_u, out_v, out_modulus, out_score, entry_valid,
		last_entry, stored_count, output ready);
endinterface

@@ sv/tks_ctrl.sv @@
// Controller: sequences push, dump and status results.
module tks_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_type,
	output logic             in_ready,
	output logic             res_valid,
	input  logic             res_ready,
	output logic             res_entry,
	output tks_pkg::cmd_t    cmd,
	input  tks_pkg::stat_t   stat
);
	tks_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tks_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		res_valid = 1'b0;
		res_entry = 1'b0;
		unique case (state_q)
			tks_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_type) begin
						cmd.load_push = 1'b1;
						state_d = tks_pkg::ST_PUSH;
					end else begin
						cmd.dump_start = 1'b1;
						state_d = stat.empty ? tks_pkg::ST_STATUS : tks_pkg::ST_DUMP;
					end
				end
			end
			tks_pkg::ST_PUSH: begin
				cmd.do_insert = 1'b1;
				state_d = tks_pkg::ST_STATUS;
			end
			tks_pkg::ST_DUMP: begin
				res_valid = 1'b1;
				res_entry = 1'b1;
				if (res_ready) begin
					cmd.dump_adv = 1'b1;
					if (stat.dump_last) state_d = tks_pkg::ST_IDLE;
				end
			end
			tks_pkg::ST_STATUS: begin
				res_valid = 1'b1;
				if (res_ready) state_d = tks_pkg::ST_IDLE;
			end
			default: state_d = tks_pkg::ST_IDLE;
		endcase
	end
endmodule

@@ sv/tks_dp.sv @@
// Datapath: sorted shift register store with a parallel insertion compare.
module tks_dp #(
	parameter int unsigned QUEUE_DEPTH = tks_pkg::QueueDepthDef,
	parameter int unsigned VALUE_BITS = tks_pkg::ValueBitsDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tks_pkg::cmd_t    cmd,
	output tks_pkg::stat_t   stat,
	input  logic             cfg_we,
	input  logic [4:0]       cfg_data,
	input  logic [31:0]      score,
	input  logic [31:0]      coord_u,
	input  logic [31:0]      coord_v,
	input  logic [31:0]      lattice_modulus,
	output logic [31:0]      out_u,
	output logic [31:0]      out_v,
	output logic [31:0]      out_modulus,
	output logic [31:0]      out_score,
	output logic [4:0]       stored_count
);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned KB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	logic [31:0]   sc_q [QUEUE_DEPTH];
	logic [95:0]   key_q [QUEUE_DEPTH];
	logic [31:0]   new_sc_q;
	logic [95:0]   new_key_q;
	logic [CW-1:0] cnt_q;
	logic [4:0]    cap_q;
	logic [IW-1:0] rd_q;
	logic [QUEUE_DEPTH-1:0] below;
	logic [CW-1:0] lim;
	logic [CW:0]   cnt_inc;

	function automatic logic [31:0] narrow(input logic [31:0] x);
		logic [31:0] m;
		m = (KB >= 32) ? 32'hFFFF_FFFF : ((32'h1 << KB) - 32'h1);
		return x & m;
	endfunction

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			// stored entry strictly below the new one: new item goes ahead of it
			below[i] = (CW'(i) < cnt_q) &&
				({tks_pkg::order_of(sc_q[i]), key_q[i]} <
				 {tks_pkg::order_of(new_sc_q), new_key_q});
		end
	end

	always_comb begin
		if ({{(CW > 5 ? CW - 5 : 0){1'b0}}, cap_q} > (CW > 5 ? CW : 5)'(QUEUE_DEPTH))
			lim = DEPTH_C;
		else
			lim = CW'(cap_q);
		cnt_inc = {1'b0, cnt_q} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cap_q <= 5'(tks_pkg::CapResetVal);
		end else begin
			if (cfg_we) cap_q <= (cfg_data == 5'd0) ? 5'd1 : cfg_data;
			if (cmd.do_insert && cnt_q < DEPTH_C && cnt_inc[CW-1:0] <= lim)
				cnt_q <= cnt_inc[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_push) begin
			new_sc_q <= score;
			new_key_q <= {narrow(coord_u), narrow(coord_v), narrow(lattice_modulus)};
		end
		if (cmd.do_insert) begin
			// shift down from the insertion point; the tail entry falls off if full
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (below[i]) begin
					if (i == 0 || !below[(i == 0) ? 0 : i - 1]) begin
						sc_q[i] <= new_sc_q;
						key_q[i] <= new_key_q;
					end else begin
						sc_q[i] <= sc_q[(i == 0) ? 0 : i - 1];
						key_q[i] <= key_q[(i == 0) ? 0 : i - 1];
					end
				end else if (CW'(i) == cnt_q && (i == 0 || !below[(i == 0) ? 0 : i - 1])) begin
					sc_q[i] <= new_sc_q;
					key_q[i] <= new_key_q;
				end else if (CW'(i) == cnt_q) begin
					sc_q[i] <= sc_q[(i == 0) ? 0 : i - 1];
					key_q[i] <= key_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_q <= '0;
		else if (cmd.dump_start) rd_q <= '0;
		else if (cmd.dump_adv) rd_q <= rd_q + 1'b1;
	end

	assign stat.empty = (cnt_q == '0);
	assign stat.dump_last = ({1'b0, rd_q} + 1'b1) == (IW + 1)'(cnt_q);
	assign out_score = sc_q[rd_q];
	assign out_u = key_q[rd_q][95:64];
	assign out_v = key_q[rd_q][63:32];
	assign out_modulus = key_q[rd_q][31:0];
	assign stored_count = 5'(cnt_q);
endmodule

@@ sv/top_k_score_keeper.sv @@
// Top level: bounded top-K score store with push and dump requests.
// Push: insert in PUSH, status held in STATUS until taken, then next item taken in IDLE.
// Dump: first entry the cycle after accept, then one entry per cycle while ready is high.
// The insertion compare runs against all slots at once.
// Reset (arst_n low, asynchronous): count 0, capacity limit 16, no result pending.
// Slot contents are not reset; only slots below the count are ever read.
module top_k_score_keeper #(
	parameter int unsigned QUEUE_DEPTH = tks_pkg::QueueDepthDef,
	parameter int unsigned VALUE_BITS = tks_pkg::ValueBitsDef
) (
	input  logic       clk,
	input  logic       arst_n,
	tks_req_if.sink    req,
	tks_res_if.source  res,
	input  logic       cfg_we,
	input  logic [4:0] cfg_data
);
	tks_pkg::cmd_t  cmd;
	tks_pkg::stat_t stat;
	logic res_entry;
	logic [31:0] u, v, m, s;

	// sequence requests
	tks_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_type(req.req_type), .in_ready(req.ready),
		.res_valid(res.valid), .res_ready(res.ready), .res_entry,
		.cmd, .stat
	);

	// hold the sorted store
	tks_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk, .arst_n, .cmd, .stat, .cfg_we, .cfg_data,
		.score(req.score), .coord_u(req.coord_u), .coord_v(req.coord_v),
		.lattice_modulus(req.lattice_modulus),
		.out_u(u), .out_v(v), .out_modulus(m), .out_score(s),
		.stored_count(res.stored_count)
	);

	// zero the entry fields on status items
	assign res.out_u = res_entry ? u : 32'h0;
	assign res.out_v = res_entry ? v : 32'h0;
	assign res.out_modulus = res_entry ? m : 32'h0;
	assign res.out_score = res_entry ? s : 32'h0;
	assign res.entry_valid = res_entry;
	assign res.last_entry = !res_entry || stat.dump_last;
endmodule

@@ sv/tks_checker.sv @@
// Checker: port-level properties of the score keeper, bound to the top level.
module tks_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       entry_valid,
	input logic       last_entry,
	input logic [4:0] stored_count
);
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> last_entry) else $error("status item not last");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		stored_count <= 5'd16) else $error("count above depth");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind top_k_score_keeper tks_checker u_chk (
	.clk, .arst_n,
	.in_ready(req.ready),
	.out_valid(res.valid), .out_ready(res.ready),
	.entry_valid(res.entry_valid), .last_entry(res.last_entry),
	.stored_count(res.stored_count)
);

@@ dv/tks_test_if.sv @@
// Testbench package: request and result item types and request codes.
package tks_test_pkg;
	typedef struct packed {
		logic        req_type;
		logic [31:0] score;
		logic [31:0] coord_u;
		logic [31:0] coord_v;
		logic [31:0] lattice_modulus;
	} tks_req_t;

	typedef struct packed {
		logic [31:0] out_u;
		logic [31:0] out_v;
		logic [31:0] out_modulus;
		logic [31:0] out_score;
		logic        entry_valid;
		logic        last_entry;
		logic [4:0]  stored_count;
	} tks_res_t;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_DUMP = 1'b1;
endpackage

@@ dv/top_k_score_keeper_test.sv @@
// Testbench top: drives random pushes and dumps, predicts the sorted store, checks results.
module top_k_score_keeper_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Depth = 16;
	localparam longint CycleLimit = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [4:0] cfg_data;

	tks_req_if req ();
	tks_res_if res ();

	top_k_score_keeper dut (
		.clk(clk), .arst_n(arst_n), .req(req), .res(res),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// Predicted store, kept sorted best first.
	logic [31:0] pred_score [Depth];
	logic [95:0] pred_key [Depth];
	int pred_count;
	int pred_limit;

	tks_test_pkg::tks_req_t pending_items[$];
	tks_test_pkg::tks_res_t expected_results[$];

	int mismatches;
	longint cycle_count;
	bit stall_long;
	int accepted_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Map score bits onto an unsigned value that sorts like the float; -0 folds onto +0.
	function automatic logic [31:0] score_rank(input logic [31:0] b);
		logic [31:0] x;
		x = (b == 32'h8000_0000) ? 32'h0 : b;
		return x[31] ? ~x : (x | 32'h8000_0000);
	endfunction

	// 1 when stored entry a orders at or above new entry b.
	function automatic bit ranks_at_least(input logic [31:0] sa, input logic [95:0] ka,
		input logic [31:0] sb, input logic [95:0] kb);
		logic [31:0] ra;
		logic [31:0] rb;
		ra = score_rank(sa);
		rb = score_rank(sb);
		if (ra != rb) return ra > rb;
		return ka >= kb;
	endfunction

	// Apply one request to the predicted store and queue the results it causes.
	task automatic predict_request(input tks_test_pkg::tks_req_t it);
		int pos;
		int n;
		int lim;
		logic [95:0] k;
		tks_test_pkg::tks_res_t r;
		lim = (pred_limit > Depth) ? Depth : pred_limit;
		n = pred_count;
		if (it.req_type == tks_test_pkg::REQ_PUSH) begin
			k = {it.coord_u, it.coord_v, it.lattice_modulus};
			pos = 0;
			while (pos < n && ranks_at_least(pred_score[pos], pred_key[pos], it.score, k))
				pos++;
			if (n < Depth) begin
				for (int i = n; i > pos; i--) begin
					pred_score[i] = pred_score[i-1];
					pred_key[i] = pred_key[i-1];
				end
				pred_score[pos] = it.score;
				pred_key[pos] = k;
				n++;
				if (n > lim) n--;
			end else if (pos < n) begin
				for (int i = n - 1; i > pos; i--) begin
					pred_score[i] = pred_score[i-1];
					pred_key[i] = pred_key[i-1];
				end
				pred_score[pos] = it.score;
				pred_key[pos] = k;
			end
			pred_count = n;
			r = '0;
			r.last_entry = 1'b1;
			r.stored_count = 5'(n);
			expected_results.push_back(r);
		end else if (n == 0) begin
			r = '0;
			r.last_entry = 1'b1;
			expected_results.push_back(r);
		end else begin
			for (int i = 0; i < n; i++) begin
				r.out_u = pred_key[i][95:64];
				r.out_v = pred_key[i][63:32];
				r.out_modulus = pred_key[i][31:0];
				r.out_score = pred_score[i];
				r.entry_valid = 1'b1;
				r.last_entry = (i + 1 == n);
				r.stored_count = 5'(n);
				expected_results.push_back(r);
			end
		end
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		if ($urandom_range(9) < 5) return 0;
		if ($urandom_range(9) < 8) return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	int send_gap;

	// Input monitor: predict each item at the edge that accepts it, then pick a gap.
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			predict_request(pending_items.pop_front());
			accepted_count++;
			send_gap = gap_length();
		end
	end

	// Driver: offer the next pending item, hold it until accepted, then idle for a gap.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (send_gap > 0) begin
				send_gap--;
				req.valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				req.valid <= 1'b1;
				req.req_type <= pending_items[0].req_type;
				req.score <= pending_items[0].score;
				req.coord_u <= pending_items[0].coord_u;
				req.coord_v <= pending_items[0].coord_v;
				req.lattice_modulus <= pending_items[0].lattice_modulus;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Receiver ready: random gaps, or a long hold-off while stall_long is set.
	int recv_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			recv_gap = 0;
		end else if (stall_long) begin
			res.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
			if ($urandom_range(3) == 0) recv_gap = gap_length();
		end
	end

	// Monitor: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		tks_test_pkg::tks_res_t got;
		tks_test_pkg::tks_res_t want;
		cycle_count++;
		if (arst_n && res.valid && res.ready) begin
			got = {res.out_u, res.out_v, res.out_modulus, res.out_score,
				res.entry_valid, res.last_entry, res.stored_count};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", want, got);
				end
			end
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		if (cycle_count > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic tks_test_pkg::tks_req_t push_item(input logic [31:0] s,
		input logic [31:0] u, input logic [31:0] v, input logic [31:0] m);
		tks_test_pkg::tks_req_t it;
		it.req_type = tks_test_pkg::REQ_PUSH;
		it.score = s;
		it.coord_u = u;
		it.coord_v = v;
		it.lattice_modulus = m;
		return it;
	endfunction

	function automatic tks_test_pkg::tks_req_t dump_item();
		tks_test_pkg::tks_req_t it;
		it = push_item($urandom, $urandom, $urandom, $urandom);
		it.req_type = tks_test_pkg::REQ_DUMP;
		return it;
	endfunction

	// Scores drawn mostly from a small pool so ties and signed zeros happen often.
	function automatic logic [31:0] rand_score();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h3F80_0000;
			3: return 32'hBF80_0000;
			4: return 32'h7F80_0000;
			5: return 32'hFF80_0000;
			default: return {1'($urandom_range(1)), 8'($urandom_range(253, 1)),
				23'($urandom)};
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(2) == 0) return 32'($urandom_range(3));
		return $urandom;
	endfunction

	// Wait until every expectation is met and the block has gone quiet.
	task automatic drain();
		while (pending_items.size() > 0 || req.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Idle register write at the falling edge.
	task automatic write_limit(input logic [4:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		pred_limit = (val == 0) ? 1 : int'(val);
	endtask

	initial begin
		logic [4:0] limits [6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.req_type = 1'b0;
		req.score = '0;
		req.coord_u = '0;
		req.coord_v = '0;
		req.lattice_modulus = '0;
		res.ready = 1'b0;
		pred_count = 0;
		pred_limit = 16;
		mismatches = 0;
		cycle_count = 0;
		stall_long = 1'b0;
		accepted_count = 0;
		for (int i = 0; i < Depth; i++) begin
			pred_score[i] = '0;
			pred_key[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty dump, extremes, signed zeros, exact ties, dumps.
		pending_items.push_back(dump_item());
		pending_items.push_back(push_item(32'h0000_0000, 32'h0, 32'h0, 32'h0));
		pending_items.push_back(push_item(32'h8000_0000, 32'h0, 32'h0, 32'h1));
		pending_items.push_back(push_item(32'hFFFF_FFFF & 32'h7F7F_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_items.push_back(push_item(32'hFF7F_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
		pending_items.push_back(push_item(32'h7F80_0000, 32'h5, 32'h5, 32'h5));
		pending_items.push_back(push_item(32'hFF80_0000, 32'h5, 32'h5, 32'h5));
		pending_items.push_back(push_item(32'h3F80_0000, 32'h1, 32'h2, 32'h3));
		pending_items.push_back(push_item(32'h3F80_0000, 32'h1, 32'h2, 32'h3));
		pending_items.push_back(push_item(32'h3F80_0000, 32'h1, 32'h2, 32'h4));
		pending_items.push_back(push_item(32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA));
		pending_items.push_back(dump_item());
		drain();

		// Capacity one (written as zero), then extremes and mid settings.
		limits[0] = 5'd0;
		limits[1] = 5'd31;
		limits[2] = 5'd3;
		limits[3] = 5'd16;
		limits[4] = 5'd1;
		limits[5] = 5'd8;
		for (int ph = 0; ph < 6; ph++) begin
			write_limit(limits[ph]);
			for (int j = 0; j < 60; j++) begin
				if ($urandom_range(5) == 0) pending_items.push_back(dump_item());
				else pending_items.push_back(push_item(rand_score(), rand_coord(),
					rand_coord(), rand_coord()));
			end
			pending_items.push_back(dump_item());
			if (ph == 3) begin
				// Hold the receiver off while the sender keeps offering items.
				stall_long = 1'b1;
				repeat (300) @(posedge clk);
				stall_long = 1'b0;
			end
			drain();
		end

		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
sv/tks_pkg.sv
sv/tks_if.sv
sv/tks_ctrl.sv
sv/tks_dp.sv
sv/top_k_score_keeper.sv
sv/tks_checker.sv
dv/tks_test_if.sv
dv/top_k_score_keeper_test.sv
